// File: rtl/core/lrpt_pkg.sv
// Shared types, constants and CORDIC angle table of the lidar point time estimator.
`default_nettype none
package lrpt_pkg;

    localparam int MAX_RINGS_DEF    = 128;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_W  = 19;
    localparam int INTEN_W  = 8;
    localparam int RAW_W    = 32;
    localparam int RING_W   = 7;
    localparam int TIME_W   = 20;
    localparam int YAW_W    = 17;
    localparam int CX_W     = 30;
    localparam int CZ_W     = 27;
    localparam int ADDR_W   = 5;
    localparam int FULL_TURN = 92160;
    localparam int REV_US    = 99723;
    localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;

    localparam logic [ADDR_W-1:0] REG_NUM_RINGS  = 5'd0;
    localparam logic [ADDR_W-1:0] REG_DECIMATION = 5'd4;
    localparam logic [ADDR_W-1:0] REG_TIME_SCALE = 5'd8;
    localparam logic [ADDR_W-1:0] REG_TIME_GIVEN = 5'd12;
    localparam logic [ADDR_W-1:0] REG_MIN_RANGE  = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RANGE, ST_CORDIC, ST_RDWAIT, ST_DIFF, ST_QUOT, ST_TIME, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic range_step;
        logic cordic_init;
        logic cordic_step;
        logic diff_step;
        logic prod_step;
        logic quot_step;
        logic time_step;
        logic write_ring;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic keep;
        logic cordic_done;
        logic given;
        logic seen;
        logic rem_done;
    } t_status;

    function automatic logic [CZ_W-1:0] atan_val(input logic [4:0] i);
        case (i)
            5'd0: atan_val = 27'd2949120;  5'd1: atan_val = 27'd1740967;
            5'd2: atan_val = 27'd919879;   5'd3: atan_val = 27'd466945;
            5'd4: atan_val = 27'd234379;   5'd5: atan_val = 27'd117304;
            5'd6: atan_val = 27'd58666;    5'd7: atan_val = 27'd29335;
            5'd8: atan_val = 27'd14668;    5'd9: atan_val = 27'd7334;
            5'd10: atan_val = 27'd3667;    5'd11: atan_val = 27'd1833;
            5'd12: atan_val = 27'd917;     5'd13: atan_val = 27'd458;
            5'd14: atan_val = 27'd229;     5'd15: atan_val = 27'd115;
            5'd16: atan_val = 27'd57;      5'd17: atan_val = 27'd29;
            5'd18: atan_val = 27'd14;      5'd19: atan_val = 27'd7;
            5'd20: atan_val = 27'd4;       5'd21: atan_val = 27'd2;
            5'd22: atan_val = 27'd1;
            default: atan_val = 27'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/lrpt_if.sv
// Valid/ready channel interfaces for input points and kept points.
`default_nettype none
interface lrpt_in_if;
    logic valid;
    logic ready;
    logic frame_start;
    logic signed [18:0] pos_x;
    logic signed [18:0] pos_y;
    logic signed [18:0] pos_z;
    logic [7:0] intensity;
    logic [31:0] raw_time;
    logic [6:0] ring;
    modport source (output valid, frame_start, pos_x, pos_y, pos_z, intensity, raw_time,
                    ring, input ready);
    modport sink (input valid, frame_start, pos_x, pos_y, pos_z, intensity, raw_time,
                  ring, output ready);
endinterface

interface lrpt_out_if;
    logic valid;
    logic ready;
    logic signed [18:0] out_x;
    logic signed [18:0] out_y;
    logic signed [18:0] out_z;
    logic [7:0] out_intensity;
    logic [19:0] time_us;
    modport source (output valid, out_x, out_y, out_z, out_intensity, time_us,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, out_intensity, time_us,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/lrpt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lrpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/lrpt_ctrl.sv
// Sequencer: walks one point through range check, CORDIC, time and output.
`default_nettype none
module lrpt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_busy,
    input  wire lrpt_pkg::t_status i_status,
    output      logic             o_in_ready,
    output      lrpt_pkg::t_cmd   o_cmd
);
    lrpt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lrpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = lrpt_pkg::ST_RANGE;
                end
            end
            lrpt_pkg::ST_RANGE: begin
                o_cmd.range_step = 1'b1;
                o_cmd.cordic_init = 1'b1;
                n_state = lrpt_pkg::ST_CORDIC;
            end
            lrpt_pkg::ST_CORDIC: begin
                if (!i_status.keep) begin
                    n_state = lrpt_pkg::ST_IDLE;
                end else if (i_status.given) begin
                    o_cmd.time_step = 1'b1;
                    n_state = lrpt_pkg::ST_OUT;
                end else if (i_status.cordic_done) begin
                    n_state = lrpt_pkg::ST_RDWAIT;
                end else begin
                    o_cmd.cordic_step = 1'b1;
                end
            end
            lrpt_pkg::ST_RDWAIT: begin
                o_cmd.diff_step = 1'b1;
                n_state = lrpt_pkg::ST_DIFF;
            end
            lrpt_pkg::ST_DIFF: begin
                // First point of a ring only records its yaw
                if (i_status.seen) begin
                    o_cmd.prod_step = 1'b1;
                    n_state = lrpt_pkg::ST_QUOT;
                end else begin
                    o_cmd.write_ring = 1'b1;
                    n_state = lrpt_pkg::ST_IDLE;
                end
            end
            lrpt_pkg::ST_QUOT: begin
                o_cmd.quot_step = 1'b1;
                n_state = lrpt_pkg::ST_TIME;
            end
            lrpt_pkg::ST_TIME: begin
                o_cmd.time_step = 1'b1;
                o_cmd.write_ring = 1'b1;
                n_state = lrpt_pkg::ST_OUT;
            end
            lrpt_pkg::ST_OUT: begin
                if (!i_out_busy && i_status.rem_done) begin
                    o_cmd.emit = 1'b1;
                    n_state = lrpt_pkg::ST_IDLE;
                end
            end
            default: n_state = lrpt_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == lrpt_pkg::ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == lrpt_pkg::ST_IDLE)
        else $error("emit not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == lrpt_pkg::ST_RANGE)
        else $error("load without range step");
endmodule
`default_nettype wire

// File: rtl/core/lrpt_dp.sv
// Datapath: range test, CORDIC atan2, yaw time, ring state and output register.
`default_nettype none
module lrpt_dp #(
    parameter int MAX_RINGS    = lrpt_pkg::MAX_RINGS_DEF,
    parameter int CORDIC_STEPS = lrpt_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lrpt_pkg::t_cmd  i_cmd,
    output      lrpt_pkg::t_status o_status,
    lrpt_in_if.sink              in_ch,
    lrpt_out_if.source           out_ch,
    input  wire logic [7:0]      i_num_rings,
    input  wire logic [6:0]      i_decimation,
    input  wire logic [31:0]     i_time_scale,
    input  wire logic            i_time_given,
    input  wire logic [17:0]     i_min_range
);
    localparam int RA_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int CX = lrpt_pkg::CX_W;
    localparam int CZ = lrpt_pkg::CZ_W;

    logic signed [18:0] r_x, r_y, r_z;
    logic [7:0]  r_inten;
    logic [31:0] r_raw;
    logic [6:0]  r_ring;
    logic [5:0]  r_index;
    logic        r_keep;
    logic [MAX_RINGS-1:0] r_seen;
    logic signed [CX-1:0] r_cx, r_cy;
    logic signed [CZ-1:0] r_cz;
    logic [4:0]  r_iter;
    logic [17:0] r_d;
    logic [35:0] r_prod;
    logic [19:0] r_q;
    logic [19:0] r_time;
    logic [6:0]  r_rem;
    logic [5:0]  r_rem_q;
    logic [2:0]  r_rem_cnt;
    logic        r_out_valid;
    logic [19:0] r_out_time;
    logic signed [18:0] r_ox, r_oy, r_oz;
    logic [7:0]  r_oi;

    logic [6:0]  n_dec;
    logic [5:0]  n_index, w_idx;
    logic [38:0] w_r2, w_m2;
    logic        w_ring_ok;
    logic [7:0]  w_rem_sh;
    logic [RA_W-1:0] w_ra;
    logic [16:0] w_first;
    logic [19:0] w_last;
    logic [36:0] w_ram_w, w_ram_r;
    logic signed [CX-1:0] w_dx, w_dy;
    logic signed [CZ-1:0] w_zr;
    logic signed [18:0] w_yaw_r, w_yaw;
    logic signed [19:0] w_diff;
    logic [63:0] w_given;
    logic [51:0] w_qfull;
    logic [19:0] w_t, w_tsat;
    logic [20:0] w_tsum;

    assign w_ra = RA_W'(r_ring);

    // Squared range against squared minimum
    always_comb begin
        w_r2 = (39'(r_x) * 39'(r_x)) + (39'(r_y) * 39'(r_y)) + (39'(r_z) * 39'(r_z));
        w_m2 = 39'(i_min_range) * 39'(i_min_range);
        w_ring_ok = ({1'b0, r_ring} < i_num_rings) && (32'(r_ring) < MAX_RINGS);
        n_dec = (i_decimation == 7'd0) ? 7'd1 : i_decimation;
        w_idx = in_ch.frame_start ? 6'd0 : r_index;
        n_index = w_idx + 6'd1;
        w_rem_sh = {r_rem, r_rem_q[5]};
    end

    // CORDIC step
    always_comb begin
        w_dx = r_cy >>> r_iter;
        w_dy = r_cx >>> r_iter;
        w_zr = (r_cz + CZ'(128)) >>> 8;
        if (w_zr > CZ'(46080)) w_yaw_r = 19'sd46080;
        else if (w_zr < -CZ'(46080)) w_yaw_r = -19'sd46080;
        else w_yaw_r = 19'(w_zr);
        w_yaw = (r_x == 0 && r_y == 0) ? 19'sd0 : w_yaw_r;
    end

    // Yaw-time division by 92416 via reciprocal multiply then correction
    always_comb begin
        w_diff = 20'(signed'(w_first)) - 20'(w_yaw);
        w_given = 64'(r_raw) * 64'(i_time_scale);
        w_qfull = 52'(r_prod) * 52'd46474;
        if (36'(r_q + 20'd1) * 36'd92416 <= r_prod) w_t = r_q + 20'd1;
        else w_t = r_q;
        w_tsum = (w_t < w_last) ? 21'(w_t) + 21'(lrpt_pkg::REV_US) : 21'(w_t);
        w_tsat = w_tsum[20] ? lrpt_pkg::TIME_MAX : w_tsum[19:0];
    end

    assign w_first = w_ram_r[36:20];
    assign w_last = w_ram_r[19:0];
    assign w_ram_w = r_seen[w_ra] ? {w_first, w_tsat} : {w_yaw[16:0], 20'd0};

    lrpt_ram #(.WIDTH(37), .DEPTH(1 << RA_W)) u_ring_ram (
        .i_clk(i_clk), .i_we(i_cmd.write_ring && r_keep), .i_waddr(w_ra),
        .i_wdata(w_ram_w), .i_raddr(w_ra), .o_rdata(w_ram_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_seen <= '0;
            r_out_valid <= 1'b0;
            r_rem_cnt <= 3'd6;
        end else begin
            if (i_cmd.load) begin
                r_index <= n_index;
                if (in_ch.frame_start) r_seen <= '0;
            end
            if (i_cmd.write_ring && r_keep) r_seen[w_ra] <= 1'b1;
            if (i_cmd.emit && r_rem == 7'd0) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            if (i_cmd.load) r_rem_cnt <= '0;
            else if (r_rem_cnt != 3'd6) r_rem_cnt <= r_rem_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= in_ch.pos_x; r_y <= in_ch.pos_y; r_z <= in_ch.pos_z;
            r_inten <= in_ch.intensity; r_raw <= in_ch.raw_time; r_ring <= in_ch.ring;
        end
        // Index remainder by decimation, one dividend bit per cycle
        if (i_cmd.load) begin
            r_rem <= '0;
            r_rem_q <= w_idx;
        end else if (r_rem_cnt != 3'd6) begin
            r_rem_q <= {r_rem_q[4:0], 1'b0};
            if (w_rem_sh >= {1'b0, n_dec}) r_rem <= 7'(w_rem_sh - {1'b0, n_dec});
            else r_rem <= w_rem_sh[6:0];
        end
        if (i_cmd.range_step) r_keep <= (w_r2 >= w_m2) && w_ring_ok;
        if (i_cmd.cordic_init) begin
            r_iter <= '0;
            if (r_x < 0) begin
                r_cx <= -(CX'(r_x) <<< 6); r_cy <= -(CX'(r_y) <<< 6);
                r_cz <= (r_y >= 0) ? CZ'(11796480) : -CZ'(11796480);
            end else begin
                r_cx <= CX'(r_x) <<< 6; r_cy <= CX'(r_y) <<< 6; r_cz <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            r_iter <= r_iter + 5'd1;
            if (r_cy >= 0) begin
                r_cx <= r_cx + w_dx; r_cy <= r_cy - w_dy;
                r_cz <= r_cz + signed'(lrpt_pkg::atan_val(r_iter));
            end else begin
                r_cx <= r_cx - w_dx; r_cy <= r_cy + w_dy;
                r_cz <= r_cz - signed'(lrpt_pkg::atan_val(r_iter));
            end
        end
        if (i_cmd.diff_step) begin
            if (w_diff < 0) r_d <= 18'(w_diff + 20'sd92160);
            else r_d <= 18'(w_diff);
        end
        if (i_cmd.prod_step) r_prod <= 36'(r_d) * 36'd100000 + 36'd46208;
        if (i_cmd.quot_step) r_q <= w_qfull[51:32];
        if (i_cmd.time_step) begin
            if (i_time_given) begin
                r_time <= (w_given[63:16] > 48'(lrpt_pkg::TIME_MAX))
                          ? lrpt_pkg::TIME_MAX : w_given[35:16];
            end else begin
                r_time <= w_tsat;
            end
        end
        if (i_cmd.emit) begin
            r_ox <= r_x; r_oy <= r_y; r_oz <= r_z; r_oi <= r_inten; r_out_time <= r_time;
        end
    end

    assign o_status.keep = r_keep;
    assign o_status.cordic_done = (32'(r_iter) >= CORDIC_STEPS) || (r_iter >= 5'd24);
    assign o_status.given = i_time_given;
    assign o_status.seen = r_seen[w_ra];
    assign o_status.rem_done = (r_rem_cnt == 3'd6);

    assign out_ch.valid = r_out_valid;
    assign out_ch.out_x = r_ox;
    assign out_ch.out_y = r_oy;
    assign out_ch.out_z = r_oz;
    assign out_ch.out_intensity = r_oi;
    assign out_ch.time_us = r_out_time;
endmodule
`default_nettype wire

// File: rtl/core/lidar_ring_point_time_estimator.sv
// Top level of the lidar ring point time estimator.
// One point is in flight at a time. A kept yaw-mode point passes through accept,
// range check, the CORDIC iterations, ring read, difference, product, quotient,
// time and output. The first point of a ring ends after the difference step. A
// given-time point goes from CORDIC to output, where it also waits for the
// bit-serial index remainder for decimation; points dropped for range or ring
// finish after the range check. A stalled output holds the point at the output
// step. A kept point waits in the output register while the next point is
// taken in. Per-ring yaw and time sit in a RAM that needs no clearing pass;
// per-ring seen flags are flip-flops cleared by reset and frame start.
`default_nettype none
module lidar_ring_point_time_estimator #(
    parameter int MAX_RINGS    = lrpt_pkg::MAX_RINGS_DEF,
    parameter int CORDIC_STEPS = lrpt_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lrpt_in_if.sink          in_ch,
    lrpt_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    logic [7:0]  r_num_rings;
    logic [6:0]  r_decimation;
    logic [31:0] r_time_scale;
    logic        r_time_given;
    logic [17:0] r_min_range;
    lrpt_pkg::t_cmd w_cmd;
    lrpt_pkg::t_status w_status;
    logic w_ready;

    assign pready = 1'b1;
    assign in_ch.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rings <= 8'd32; r_decimation <= 7'd1; r_time_scale <= 32'd65536;
            r_time_given <= 1'b0; r_min_range <= 18'd4000;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                lrpt_pkg::REG_NUM_RINGS:  r_num_rings <= pwdata[7:0];
                lrpt_pkg::REG_DECIMATION: r_decimation <= pwdata[6:0];
                lrpt_pkg::REG_TIME_SCALE: r_time_scale <= pwdata;
                lrpt_pkg::REG_TIME_GIVEN: r_time_given <= pwdata[0];
                lrpt_pkg::REG_MIN_RANGE:  r_min_range <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            lrpt_pkg::REG_NUM_RINGS:  prdata = 32'(r_num_rings);
            lrpt_pkg::REG_DECIMATION: prdata = 32'(r_decimation);
            lrpt_pkg::REG_TIME_SCALE: prdata = r_time_scale;
            lrpt_pkg::REG_TIME_GIVEN: prdata = 32'(r_time_given);
            lrpt_pkg::REG_MIN_RANGE:  prdata = 32'(r_min_range);
            default: prdata = 32'd0;
        endcase
    end

    lrpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .i_out_busy(out_ch.valid && !out_ch.ready), .i_status(w_status),
        .o_in_ready(w_ready), .o_cmd(w_cmd)
    );

    lrpt_dp #(.MAX_RINGS(MAX_RINGS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .in_ch(in_ch), .out_ch(out_ch), .i_num_rings(r_num_rings),
        .i_decimation(r_decimation), .i_time_scale(r_time_scale),
        .i_time_given(r_time_given), .i_min_range(r_min_range)
    );
endmodule
`default_nettype wire
